### hw/rtl/qte_pkg.sv
// Shared types, width helpers and the arctangent table for the quaternion to
// Euler angle pipeline. No dependencies.
package qte_pkg;

  localparam int ANG_FRAC = 20;
  localparam int ANG_W    = 32;
  localparam int ATAN_LEN = 32;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [15:0]      centi_t;

  localparam ang_t ANG_HALF_TURN = ang_t'(180) <<< ANG_FRAC;
  localparam centi_t LIM_HALF    = 16'sd18000;
  localparam centi_t LIM_QUARTER = 16'sd9000;

  // Width of the exact Q(2F) sums.
  function automatic int tw_of(input int f);
    return ((2 * f > 32) ? 2 * f : 32) + 3;
  endfunction

  function automatic int shl_of(input int f);
    return (2 * f < 30) ? 30 - 2 * f : 0;
  endfunction

  function automatic int shr_of(input int f);
    return (2 * f > 30) ? 2 * f - 30 : 0;
  endfunction

  // Width of an operand after rescaling to Q30.
  function automatic int qw_of(input int f);
    return tw_of(f) + shl_of(f) - shr_of(f);
  endfunction

  // atan(2^-i) in degrees times 2^20, rounded to nearest.
  function automatic ang_t atan_entry(input int unsigned i);
    ang_t a;
    case (i)
      0:  a = 47185920;  1:  a = 27855475;  2:  a = 14718068;  3:  a = 7471121;
      4:  a = 3750058;   5:  a = 1876857;   6:  a = 938658;    7:  a = 469357;
      8:  a = 234682;    9:  a = 117342;    10: a = 58671;     11: a = 29335;
      12: a = 14668;     13: a = 7334;      14: a = 3667;      15: a = 1833;
      16: a = 917;       17: a = 458;       18: a = 229;       19: a = 115;
      20: a = 57;        21: a = 29;        22: a = 14;        23: a = 7;
      24: a = 4;         25: a = 2;         26: a = 1;
      default: a = 0;
    endcase
    return a;
  endfunction

  // Degrees times 2^20 to centidegrees, rounding half up, saturated to +-lim.
  function automatic centi_t to_centi(input ang_t z, input centi_t lim);
    logic signed [ANG_W+7:0] p;
    logic signed [ANG_W+7:0] c;
    logic signed [ANG_W+7:0] l;
    p = (ANG_W + 8)'(z) * (ANG_W + 8)'(100);
    p = p + ((ANG_W + 8)'(1) <<< (ANG_FRAC - 1));
    c = p >>> ANG_FRAC;
    l = (ANG_W + 8)'(lim);
    if (c > l) begin
      c = l;
    end
    if (c < -l) begin
      c = -l;
    end
    return centi_t'(c);
  endfunction

endpackage

### hw/rtl/qte_front.sv
// Front end: quaternion products, the five sums, Q30 rescale, and the pitch
// square-root radicand. Four register stages. Depends on qte_pkg.
module qte_front #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic out_valid,
  output logic signed [qte_pkg::qw_of(QUAT_FRAC_BITS)-1:0] roll_y,
  output logic signed [qte_pkg::qw_of(QUAT_FRAC_BITS)-1:0] roll_x,
  output logic signed [qte_pkg::qw_of(QUAT_FRAC_BITS)-1:0] yaw_y,
  output logic signed [qte_pkg::qw_of(QUAT_FRAC_BITS)-1:0] yaw_x,
  output logic signed [31:0] pitch_s,
  output logic [60:0] rad
);
  import qte_pkg::*;

  localparam int TW  = tw_of(QUAT_FRAC_BITS);
  localparam int SHL = shl_of(QUAT_FRAC_BITS);
  localparam int SHR = shr_of(QUAT_FRAC_BITS);
  localparam int QW  = qw_of(QUAT_FRAC_BITS);

  typedef logic signed [QW-1:0] q_t;

  function automatic q_t to_q30(input logic signed [TW-1:0] t);
    logic signed [TW+SHL-1:0] e;
    e = (TW + SHL)'(t);
    e = (e <<< SHL) >>> SHR;
    return QW'(e);
  endfunction

  // Stage 1: products.
  logic v1;
  logic signed [31:0] p_wx, p_yz, p_wy, p_zx, p_wz, p_xy, p_xx, p_yy, p_zz;
  // Stage 2: rescaled operands.
  logic v2;
  q_t r0, r1, r3, r4;
  logic signed [31:0] s2;
  // Stage 3: square of the pitch sine.
  logic v3;
  q_t r0_3, r1_3, r3_3, r4_3;
  logic signed [31:0] s3;
  logic signed [63:0] sq;

  logic signed [TW-1:0] one, t0, t1, t2, t3, t4;

  always_comb begin
    one = TW'(1) <<< (2 * QUAT_FRAC_BITS);
    t0 = (TW'(p_wx) + TW'(p_yz)) <<< 1;
    t1 = one - ((TW'(p_xx) + TW'(p_yy)) <<< 1);
    t2 = (TW'(p_wy) - TW'(p_zx)) <<< 1;
    t3 = (TW'(p_wz) + TW'(p_xy)) <<< 1;
    t4 = one - ((TW'(p_yy) + TW'(p_zz)) <<< 1);
    if (t2 > one) begin
      t2 = one;
    end
    if (t2 < -one) begin
      t2 = -one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
    if (en) begin
      p_wx <= 32'(quat_w) * 32'(quat_x);
      p_yz <= 32'(quat_y) * 32'(quat_z);
      p_wy <= 32'(quat_w) * 32'(quat_y);
      p_zx <= 32'(quat_z) * 32'(quat_x);
      p_wz <= 32'(quat_w) * 32'(quat_z);
      p_xy <= 32'(quat_x) * 32'(quat_y);
      p_xx <= 32'(quat_x) * 32'(quat_x);
      p_yy <= 32'(quat_y) * 32'(quat_y);
      p_zz <= 32'(quat_z) * 32'(quat_z);
      r0 <= to_q30(t0);
      r1 <= to_q30(t1);
      r3 <= to_q30(t3);
      r4 <= to_q30(t4);
      s2 <= 32'(to_q30(t2));
      r0_3 <= r0;
      r1_3 <= r1;
      r3_3 <= r3;
      r4_3 <= r4;
      s3 <= s2;
      sq <= 64'(s2) * 64'(s2);
      roll_y <= r0_3;
      roll_x <= r1_3;
      yaw_y <= r3_3;
      yaw_x <= r4_3;
      pitch_s <= s3;
      rad <= 61'((64'sd1 <<< 60) - sq);
    end
  end

endmodule

### hw/rtl/qte_isqrt.sv
// Pipelined integer square root of a 61-bit radicand, one result bit per
// stage, with a side word that travels alongside. Depends on nothing.
module qte_isqrt #(
  parameter int SW = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [60:0] rad,
  input  logic [SW-1:0] in_side,
  output logic out_valid,
  output logic [30:0] root,
  output logic [SW-1:0] out_side
);
  localparam int NS = 31;

  logic [61:0] nn [0:NS-1];
  logic [61:0] rr [0:NS-1];
  logic        vv [0:NS-1];
  logic [SW-1:0] sd [0:NS-1];

  logic [61:0] src_n [0:NS-1];
  logic [61:0] src_r [0:NS-1];
  logic [61:0] nxt_n [0:NS-1];
  logic [61:0] nxt_r [0:NS-1];

  always_comb begin
    src_n[0] = 62'(rad);
    src_r[0] = '0;
    for (int k = 1; k < NS; k++) begin
      src_n[k] = nn[k-1];
      src_r[k] = rr[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      logic [61:0] b;
      b = 62'(1) << (60 - 2 * k);
      if (src_n[k] >= src_r[k] + b) begin
        nxt_n[k] = src_n[k] - (src_r[k] + b);
        nxt_r[k] = (src_r[k] >> 1) + b;
      end else begin
        nxt_n[k] = src_n[k];
        nxt_r[k] = src_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        vv[k] <= 1'b0;
      end
    end else if (en) begin
      vv[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        vv[k] <= vv[k-1];
      end
    end
    if (en) begin
      sd[0] <= in_side;
      for (int k = 1; k < NS; k++) begin
        sd[k] <= sd[k-1];
      end
      for (int k = 0; k < NS; k++) begin
        nn[k] <= nxt_n[k];
        rr[k] <= nxt_r[k];
      end
    end
  end

  assign out_valid = vv[NS-1];
  assign root      = rr[NS-1][30:0];
  assign out_side  = sd[NS-1];

endmodule

### hw/rtl/qte_cordic.sv
// Unrolled CORDIC vectoring pipeline giving atan2(y, x) in degrees times 2^20.
// One register stage for the half-turn pre-rotation, then one per iteration.
// Depends on qte_pkg.
module qte_cordic #(
  parameter int DW = 37,
  parameter int STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [DW-1:0] in_y,
  input  logic signed [DW-1:0] in_x,
  output logic out_valid,
  output qte_pkg::ang_t angle
);
  import qte_pkg::*;

  localparam int CW = DW + 2;

  logic signed [CW-1:0] xs [0:STAGES];
  logic signed [CW-1:0] ys [0:STAGES];
  ang_t                 zs [0:STAGES];
  logic                 zero [0:STAGES];
  logic                 vs [0:STAGES];

  logic signed [CW-1:0] x0, y0;
  ang_t                 z0;
  logic signed [CW-1:0] xn [0:STAGES-1];
  logic signed [CW-1:0] yn [0:STAGES-1];
  ang_t                 zn [0:STAGES-1];

  always_comb begin
    x0 = CW'(in_x);
    y0 = CW'(in_y);
    z0 = '0;
    // A vector in the left half-plane is turned by half a turn first.
    if (in_x < 0) begin
      z0 = (in_y >= 0) ? ANG_HALF_TURN : -ANG_HALF_TURN;
      x0 = -x0;
      y0 = -y0;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (ys[i] >= 0) begin
        xn[i] = xs[i] + (ys[i] >>> i);
        yn[i] = ys[i] - (xs[i] >>> i);
        zn[i] = zs[i] + atan_entry(i);
      end else begin
        xn[i] = xs[i] - (ys[i] >>> i);
        yn[i] = ys[i] + (xs[i] >>> i);
        zn[i] = zs[i] - atan_entry(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= STAGES; i++) begin
        vs[i] <= 1'b0;
      end
    end else if (en) begin
      vs[0] <= in_valid;
      for (int i = 0; i < STAGES; i++) begin
        vs[i+1] <= vs[i];
      end
    end
    if (en) begin
      xs[0] <= x0;
      ys[0] <= y0;
      zs[0] <= z0;
      zero[0] <= (in_x == 0) && (in_y == 0);
      for (int i = 0; i < STAGES; i++) begin
        xs[i+1] <= xn[i];
        ys[i+1] <= yn[i];
        zs[i+1] <= zn[i];
        zero[i+1] <= zero[i];
      end
    end
  end

  assign out_valid = vs[STAGES];
  assign angle     = zero[STAGES] ? '0 : zs[STAGES];

endmodule

### hw/rtl/quaternion_to_euler_angles.sv
// Quaternion to ZYX Euler angles (roll, pitch, yaw) in centidegrees.
// Pipeline stages from input word to output word: four front stages, 31 square-root
// stages, 1 + CORDIC_STAGES CORDIC stages and two output stages.
// Throughput: one word per cycle; the whole pipeline holds while an output word waits.
// Reset: all valid bits clear and yaw_offset returns to 2200 (22 degrees).
// Depends on qte_pkg, qte_front, qte_isqrt and qte_cordic.
module quaternion_to_euler_angles #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [16:0] yaw_angle,
  input  logic cfg_we,
  input  logic signed [15:0] cfg_wdata
);
  import qte_pkg::*;

  localparam int QW = qw_of(QUAT_FRAC_BITS);
  localparam int SW = 4 * QW + 32;

  logic en;
  logic signed [15:0] yaw_offset;

  logic f_valid;
  logic signed [QW-1:0] f_roll_y, f_roll_x, f_yaw_y, f_yaw_x;
  logic signed [31:0] f_s;
  logic [60:0] f_rad;

  logic q_valid;
  logic [30:0] q_root;
  logic [SW-1:0] q_side;
  logic signed [QW-1:0] q_roll_y, q_roll_x, q_yaw_y, q_yaw_x, q_pit_y, q_pit_x;
  logic signed [31:0] q_s;

  logic c_valid, c_valid_p, c_valid_y;
  ang_t z_roll, z_pitch, z_yaw;

  logic v_centi;
  centi_t c_roll, c_pitch, c_yaw;

  // Every stage advances together unless the output word is held.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  qte_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(f_valid), .roll_y(f_roll_y), .roll_x(f_roll_x),
    .yaw_y(f_yaw_y), .yaw_x(f_yaw_x), .pitch_s(f_s), .rad(f_rad)
  );

  qte_isqrt #(.SW(SW)) u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid), .rad(f_rad),
    .in_side({f_roll_y, f_roll_x, f_yaw_y, f_yaw_x, f_s}),
    .out_valid(q_valid), .root(q_root), .out_side(q_side)
  );

  assign {q_roll_y, q_roll_x, q_yaw_y, q_yaw_x, q_s} = q_side;
  assign q_pit_y = QW'(q_s);
  assign q_pit_x = QW'({1'b0, q_root});

  qte_cordic #(.DW(QW), .STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid),
    .in_y(q_roll_y), .in_x(q_roll_x), .out_valid(c_valid), .angle(z_roll)
  );

  qte_cordic #(.DW(QW), .STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid),
    .in_y(q_pit_y), .in_x(q_pit_x), .out_valid(c_valid_p), .angle(z_pitch)
  );

  qte_cordic #(.DW(QW), .STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid),
    .in_y(q_yaw_y), .in_x(q_yaw_x), .out_valid(c_valid_y), .angle(z_yaw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_offset <= 16'sd2200;
      v_centi <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        yaw_offset <= cfg_wdata;
      end
      if (en) begin
        v_centi <= c_valid;
        out_valid <= v_centi;
      end
    end
    if (en) begin
      c_roll  <= to_centi(z_roll, LIM_HALF);
      c_pitch <= to_centi(z_pitch, LIM_QUARTER);
      c_yaw   <= to_centi(z_yaw, LIM_HALF);
      roll_angle  <= c_roll;
      pitch_angle <= 15'(c_pitch);
      yaw_angle   <= 17'(c_yaw) - 17'(yaw_offset);
    end
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (c_valid == c_valid_p) && (c_valid == c_valid_y))
    else $error("CORDIC lanes out of step");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_angle <= 16'sd18000) && (roll_angle >= -16'sd18000))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 15'sd9000) && (pitch_angle >= -15'sd9000))
    else $error("pitch out of range");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("pipeline stalled without a held output word");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !v_centi)
    else $error("valid survived reset");

endmodule

### tb/quaternion_to_euler_angles_test.sv
// Self-checking testbench for quaternion_to_euler_angles: a directed table and random
// quaternions checked against a bit-exact angle predictor. Depends on the RTL only.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_test;

  localparam int QF = 14;
  localparam int STAGES = 16;
  localparam int PIPE_DRAIN = 80;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int RAND_PER_PHASE = 390;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [16:0] yaw;
  } euler_t;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] quat_w = '0;
  logic signed [15:0] quat_x = '0;
  logic signed [15:0] quat_y = '0;
  logic signed [15:0] quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [16:0] yaw_angle;
  logic cfg_we = 1'b0;
  logic signed [15:0] cfg_wdata = '0;

  euler_t pending_angles[$];
  longint heading_trim = 2200;
  int fail_count = 0;
  longint cycle_count = 0;
  bit no_idle = 1'b0;

  // atan(2^-i) in degrees scaled by 2^20.
  longint atan_deg_q20[0:31] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0};

  quat_t directed_rows[] = '{
    '{16384, 0, 0, 0}, '{0, 0, 0, 0}, '{-16384, 0, 0, 0}, '{0, 16384, 0, 0},
    '{0, 0, 16384, 0}, '{0, 0, 0, 16384}, '{0, 0, 0, -16384}, '{0, -16384, 0, 0},
    '{32767, 32767, 32767, 32767}, '{-32768, -32768, -32768, -32768},
    '{32767, -32768, 32767, -32768}, '{-32768, 32767, -32768, 32767},
    '{32767, 0, 32767, 0}, '{32767, 0, -32768, 0}, '{8192, 8192, 8192, 8192},
    '{8192, -8192, 8192, -8192}, '{11585, 11585, 0, 0}, '{11585, 0, 11585, 0},
    '{11585, 0, 0, 11585}, '{11585, 0, 0, -11585}, '{0, 11585, 11585, 0},
    '{1, -1, 1, -1}, '{16383, 100, -100, 50}, '{-1, 0, 0, 1}};

  quaternion_to_euler_angles DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic longint rescale_q30(longint v);
    if (2 * QF >= 30) begin
      return v >>> (2 * QF - 30);
    end
    return v <<< (30 - 2 * QF);
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint ang;
    longint dx;
    longint dy;
    ang = 0;
    if (xv == 0 && yv == 0) begin
      return 0;
    end
    if (xv < 0) begin
      ang = (yv >= 0) ? (longint'(180) <<< 20) : -(longint'(180) <<< 20);
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = xv >>> i;
      dy = yv >>> i;
      if (yv >= 0) begin
        xv = xv + dy;
        yv = yv - dx;
        ang = ang + atan_deg_q20[i];
      end else begin
        xv = xv - dy;
        yv = yv + dx;
        ang = ang - atan_deg_q20[i];
      end
    end
    return ang;
  endfunction

  function automatic longint centidegrees(longint ang, longint lim);
    longint c;
    c = (ang * 100 + (longint'(1) <<< 19)) >>> 20;
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    return c;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic euler_t euler_of(quat_t q, longint trim);
    longint w, x, y, z, one, t0, t1, t2, t3, t4, s, c, yaw;
    euler_t e;
    w = longint'(q.w);
    x = longint'(q.x);
    y = longint'(q.y);
    z = longint'(q.z);
    one = longint'(1) <<< (2 * QF);
    t0 = 2 * (w * x + y * z);
    t1 = one - 2 * (x * x + y * y);
    t2 = 2 * (w * y - z * x);
    t3 = 2 * (w * z + x * y);
    t4 = one - 2 * (y * y + z * z);
    if (t2 > one) t2 = one;
    if (t2 < -one) t2 = -one;
    e.roll = 16'(centidegrees(vector_angle(rescale_q30(t0), rescale_q30(t1)), 18000));
    s = rescale_q30(t2);
    if (s > (longint'(1) <<< 30)) s = longint'(1) <<< 30;
    if (s < -(longint'(1) <<< 30)) s = -(longint'(1) <<< 30);
    c = longint'(floor_sqrt((longint'(1) << 60) - s * s));
    e.pitch = 15'(centidegrees(vector_angle(s, c), 9000));
    yaw = centidegrees(vector_angle(rescale_q30(t3), rescale_q30(t4)), 18000) - trim;
    e.yaw = 17'(yaw);
    return e;
  endfunction

  task automatic send_quat(quat_t q);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid = 1'b1;
    quat_w = q.w;
    quat_x = q.x;
    quat_y = q.y;
    quat_z = q.z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_angles.push_back(euler_of(q, heading_trim));
    @(negedge clk);
  endtask

  // Offset writes happen only with the pipeline empty.
  task automatic write_heading_trim(logic signed [15:0] v);
    in_valid = 1'b0;
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    heading_trim = longint'(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic quat_t random_quat();
    quat_t q;
    case ($urandom_range(0, 3))
      0: begin
        q.w = 16'($urandom);
        q.x = 16'($urandom);
        q.y = 16'($urandom);
        q.z = 16'($urandom);
      end
      1: begin
        // Roughly unit-sized components.
        q.w = 16'($urandom_range(0, 32768) - 16384);
        q.x = 16'($urandom_range(0, 32768) - 16384);
        q.y = 16'($urandom_range(0, 23170) - 11585);
        q.z = 16'($urandom_range(0, 23170) - 11585);
      end
      2: begin
        // Near gimbal lock so the pitch argument clamps or nearly does.
        q.w = 16'($urandom_range(11000, 12600));
        q.y = $urandom_range(0, 1) ? q.w : -q.w;
        q.x = 16'($urandom_range(0, 400) - 200);
        q.z = 16'($urandom_range(0, 400) - 200);
      end
      default: begin
        q.w = 16'($urandom_range(0, 200) - 100);
        q.x = 16'($urandom_range(0, 200) - 100);
        q.y = 16'($urandom_range(0, 200) - 100);
        q.z = 16'($urandom_range(0, 200) - 100);
      end
    endcase
    return q;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("quaternion_to_euler_angles regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (no_idle) begin
      out_ready = 1'b1;
    end else if (out_ready && $urandom_range(0, 7) == 0) begin
      out_ready = 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    euler_t exp_e;
    if (!rst && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        exp_e = pending_angles.pop_front();
        if (roll_angle !== exp_e.roll) begin
          $error("roll_angle expected %0d actual %0d", exp_e.roll, roll_angle);
          fail_count++;
        end
        if (pitch_angle !== exp_e.pitch) begin
          $error("pitch_angle expected %0d actual %0d", exp_e.pitch, pitch_angle);
          fail_count++;
        end
        if (yaw_angle !== exp_e.yaw) begin
          $error("yaw_angle expected %0d actual %0d", exp_e.yaw, yaw_angle);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic signed [15:0] trims[5];
    trims = '{-16'sd18000, 16'sd18000, 16'sd0, 16'($urandom_range(0, 36000) - 18000),
              16'($urandom_range(0, 36000) - 18000)};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed_rows[i]) send_quat(directed_rows[i]);
    foreach (trims[p]) begin
      write_heading_trim(trims[p]);
      if (p == 4) no_idle = 1'b1;
      repeat (RAND_PER_PHASE) send_quat(random_quat());
    end
    in_valid = 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("quaternion_to_euler_angles regression: pass");
    end else begin
      $display("quaternion_to_euler_angles regression: fail");
    end
    $finish;
  end

endmodule
